// ----- rtl/core/tisd_pkg.sv -----
// Shared types, codes and helpers of the TIM image stream decoder.
package tisd_pkg;

  localparam int unsigned MaxPalettes = 9;

  // Parser phase codes
  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_PALHDR  = 3'd1;
  localparam logic [2:0] PH_PALDATA = 3'd2;
  localparam logic [2:0] PH_IMGHDR  = 3'd3;
  localparam logic [2:0] PH_PIXELS  = 3'd4;
  localparam logic [2:0] PH_IDLE    = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_COLOUR = 3'd0;
  localparam logic [2:0] KIND_INDEX  = 3'd1;
  localparam logic [2:0] KIND_DIRECT = 3'd2;
  localparam logic [2:0] KIND_BADTAG = 3'd3;
  localparam logic [2:0] KIND_BADPAL = 3'd4;

  // Image kinds
  localparam logic [1:0] FMT_16BIT = 2'd0;
  localparam logic [1:0] FMT_8BIT  = 2'd1;
  localparam logic [1:0] FMT_4BIT  = 2'd2;

  // Tag bytes
  localparam logic [7:0] TAG_MAGIC = 8'h10;
  localparam logic [7:0] TAG_4BIT  = 8'h08;
  localparam logic [7:0] TAG_8BIT  = 8'h09;
  localparam logic [7:0] TAG_16BIT = 8'h02;

  // Header byte positions
  localparam logic [3:0] HB_FORMAT = 4'd4;
  localparam logic [3:0] HB_TAGEND = 4'd7;
  localparam logic [3:0] HB_LO0    = 4'd8;
  localparam logic [3:0] HB_HI0    = 4'd9;
  localparam logic [3:0] HB_LO1    = 4'd10;
  localparam logic [3:0] HB_END    = 4'd11;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pixel_index;
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
    logic [7:0] alpha;
    logic [1:0] image_kind;
    logic       run_last;
    logic       image_done;
  } tisd_res_t;

  function automatic tisd_res_t mk_res(input logic [2:0]  kind,
                                       input logic [7:0]  idx,
                                       input logic [15:0] word,
                                       input logic        colour,
                                       input logic [1:0]  ik,
                                       input logic        done);
    tisd_res_t res;
    res.kind        = kind;
    res.pixel_index = idx;
    res.red         = colour ? word[15:11] : 5'd0;
    res.green       = colour ? word[10:6]  : 5'd0;
    res.blue        = colour ? word[5:1]   : 5'd0;
    res.alpha       = (colour && word[0]) ? 8'hff : 8'h00;
    res.image_kind  = ik;
    res.run_last    = 1'b0;
    res.image_done  = done;
    return res;
  endfunction

endpackage

// ----- rtl/core/tisd_parser.sv -----
// Byte parser: header, palette and pixel state, up to two results per byte.
module tisd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          data_byte,
  input  logic                file_start,
  output logic [1:0]          res_cnt,
  output tisd_pkg::tisd_res_t res0,
  output tisd_pkg::tisd_res_t res1
);
  import tisd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [15:0] cpp_r, cpp_nxt;
  logic [3:0]  pal_tot_r, pal_tot_nxt;
  logic [3:0]  pal_cnt_r, pal_cnt_nxt;
  logic [15:0] col_cnt_r, col_cnt_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [31:0] words_r, words_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        parity_r, parity_nxt;
  logic        mismatch_r, mismatch_nxt;

  logic [15:0] word;
  logic        second;
  logic        last;

  // a new file always parses as a tag byte, so the held byte never needs clearing here
  assign word = {data_byte, low_r};

  always_comb begin
    // a new file clears everything before the byte is parsed
    phase_nxt    = file_start ? PH_TAG : phase_r;
    hdr_cnt_nxt  = file_start ? 4'd0   : hdr_cnt_r;
    fmt_nxt      = file_start ? 2'd0   : fmt_r;
    cpp_nxt      = file_start ? 16'd0  : cpp_r;
    pal_tot_nxt  = file_start ? 4'd0   : pal_tot_r;
    pal_cnt_nxt  = file_start ? 4'd0   : pal_cnt_r;
    col_cnt_nxt  = file_start ? 16'd0  : col_cnt_r;
    width_nxt    = file_start ? 16'd0  : width_r;
    height_nxt   = file_start ? 16'd0  : height_r;
    words_nxt    = file_start ? 32'd0  : words_r;
    low_nxt      = file_start ? 8'd0   : low_r;
    parity_nxt   = file_start ? 1'b0   : parity_r;
    mismatch_nxt = file_start ? 1'b0   : mismatch_r;
    second       = parity_nxt;
    last         = 1'b0;
    res_cnt      = 2'd0;
    res0         = mk_res(KIND_COLOUR, 8'd0, 16'd0, 1'b0, FMT_16BIT, 1'b0);
    res1         = res0;

    case (phase_nxt)
      PH_TAG: begin
        if (hdr_cnt_nxt == 4'd0) begin
          if (data_byte != TAG_MAGIC) mismatch_nxt = 1'b1;
        end else if (hdr_cnt_nxt == HB_FORMAT) begin
          if (data_byte == TAG_4BIT) fmt_nxt = FMT_4BIT;
          else if (data_byte == TAG_8BIT) fmt_nxt = FMT_8BIT;
          else if (data_byte == TAG_16BIT) fmt_nxt = FMT_16BIT;
          else mismatch_nxt = 1'b1;
        end else if (data_byte != 8'd0) begin
          mismatch_nxt = 1'b1;
        end
        if (hdr_cnt_nxt >= HB_TAGEND) begin
          hdr_cnt_nxt = 4'd0;
          if (mismatch_nxt) begin
            res0      = mk_res(KIND_BADTAG, 8'd0, 16'd0, 1'b0, FMT_16BIT, 1'b1);
            res_cnt   = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = (fmt_nxt == FMT_16BIT) ? PH_IMGHDR : PH_PALHDR;
          end
        end else begin
          hdr_cnt_nxt = hdr_cnt_nxt + 4'd1;
        end
      end
      PH_PALHDR: begin
        if (hdr_cnt_nxt >= HB_END) begin
          hdr_cnt_nxt = 4'd0;
          if (word == 16'd0 || word > 16'(MaxPalettes)) begin
            res0      = mk_res(KIND_BADPAL, 8'd0, 16'd0, 1'b0, fmt_nxt, 1'b1);
            res_cnt   = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            pal_tot_nxt = word[3:0];
            pal_cnt_nxt = 4'd0;
            col_cnt_nxt = 16'd0;
            parity_nxt  = 1'b0;
            phase_nxt   = (cpp_nxt == 16'd0) ? PH_IMGHDR : PH_PALDATA;
          end
        end else begin
          if (hdr_cnt_nxt == HB_LO0 || hdr_cnt_nxt == HB_LO1) low_nxt = data_byte;
          else if (hdr_cnt_nxt == HB_HI0) cpp_nxt = word;
          hdr_cnt_nxt = hdr_cnt_nxt + 4'd1;
        end
      end
      PH_PALDATA: begin
        if (!second) begin
          low_nxt    = data_byte;
          parity_nxt = 1'b1;
        end else begin
          parity_nxt = 1'b0;
          if (pal_cnt_nxt == 4'd0) begin
            res0    = mk_res(KIND_COLOUR, 8'd0, word, 1'b1, fmt_nxt, 1'b0);
            res_cnt = 2'd1;
          end
          col_cnt_nxt = col_cnt_nxt + 16'd1;
          if (col_cnt_nxt >= cpp_nxt) begin
            col_cnt_nxt = 16'd0;
            pal_cnt_nxt = pal_cnt_nxt + 4'd1;
            if (pal_cnt_nxt >= pal_tot_nxt) begin
              phase_nxt   = PH_IMGHDR;
              hdr_cnt_nxt = 4'd0;
            end
          end
        end
      end
      PH_IMGHDR: begin
        if (hdr_cnt_nxt >= HB_END) begin
          height_nxt  = word;
          hdr_cnt_nxt = 4'd0;
          words_nxt   = 32'(width_nxt) * 32'(word);
          parity_nxt  = 1'b0;
          phase_nxt   = (width_nxt == 16'd0 || word == 16'd0) ? PH_IDLE : PH_PIXELS;
        end else begin
          if (hdr_cnt_nxt == HB_LO0 || hdr_cnt_nxt == HB_LO1) low_nxt = data_byte;
          else if (hdr_cnt_nxt == HB_HI0) width_nxt = word;
          hdr_cnt_nxt = hdr_cnt_nxt + 4'd1;
        end
      end
      PH_PIXELS: begin
        last = second && (words_nxt == 32'd1);
        if (fmt_nxt == FMT_8BIT) begin
          res0    = mk_res(KIND_INDEX, data_byte, 16'd0, 1'b0, FMT_8BIT, last);
          res_cnt = 2'd1;
        end else if (fmt_nxt == FMT_4BIT) begin
          // low nibble first
          res0    = mk_res(KIND_INDEX, {4'd0, data_byte[3:0]}, 16'd0, 1'b0, FMT_4BIT, 1'b0);
          res1    = mk_res(KIND_INDEX, {4'd0, data_byte[7:4]}, 16'd0, 1'b0, FMT_4BIT, last);
          res_cnt = 2'd2;
        end else if (second) begin
          res0    = mk_res(KIND_DIRECT, 8'd0, word, 1'b1, FMT_16BIT, last);
          res_cnt = 2'd1;
        end
        if (second) begin
          parity_nxt = 1'b0;
          words_nxt  = words_nxt - 32'd1;
          if (words_nxt == 32'd0) phase_nxt = PH_IDLE;
        end else begin
          low_nxt    = data_byte;
          parity_nxt = 1'b1;
        end
      end
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      hdr_cnt_r  <= 4'd0;
      fmt_r      <= 2'd0;
      cpp_r      <= 16'd0;
      pal_tot_r  <= 4'd0;
      pal_cnt_r  <= 4'd0;
      col_cnt_r  <= 16'd0;
      width_r    <= 16'd0;
      height_r   <= 16'd0;
      words_r    <= 32'd0;
      low_r      <= 8'd0;
      parity_r   <= 1'b0;
      mismatch_r <= 1'b0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      fmt_r      <= fmt_nxt;
      cpp_r      <= cpp_nxt;
      pal_tot_r  <= pal_tot_nxt;
      pal_cnt_r  <= pal_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      words_r    <= words_nxt;
      low_r      <= low_nxt;
      parity_r   <= parity_nxt;
      mismatch_r <= mismatch_nxt;
    end
  end

  property p_pixels_need_words;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == PH_PIXELS) |-> (words_r != 32'd0);
  endproperty
  a_pixels_need_words: assert property (p_pixels_need_words)
    else $error("pixel phase with no words left");

  property p_idle_holds;
    @(posedge clk) disable iff (!rst_n)
      (phase_r == PH_IDLE && adv && !file_start) |-> (res_cnt == 2'd0);
  endproperty
  a_idle_holds: assert property (p_idle_holds)
    else $error("result produced after end of file");

  property p_pair_only_4bit;
    @(posedge clk) disable iff (!rst_n)
      (res_cnt == 2'd2) |-> (res1.image_kind == FMT_4BIT);
  endproperty
  a_pair_only_4bit: assert property (p_pair_only_4bit)
    else $error("two results from a non 4-bit byte");

endmodule

// ----- rtl/core/tisd_res_buf.sv -----
// Result register: holds up to two results of one byte and drains them beat by beat.
module tisd_res_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  logic [1:0]          res_cnt,
  input  tisd_pkg::tisd_res_t res0,
  input  tisd_pkg::tisd_res_t res1,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output tisd_pkg::tisd_res_t out_res
);
  import tisd_pkg::*;

  logic      v0_r, v0_nxt;
  logic      v1_r, v1_nxt;
  tisd_res_t s0_r, s0_nxt;
  tisd_res_t s1_r, s1_nxt;
  logic      take;

  assign take      = v0_r && out_ready;
  // load only when the register is empty after this cycle
  assign can_load  = !v0_r || (out_ready && !v1_r);
  assign out_valid = v0_r;
  assign out_res   = s0_r;

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (take) begin
      v0_nxt = v1_r;
      s0_nxt = s1_r;
      v1_nxt = 1'b0;
    end
    if (ld && res_cnt != 2'd0) begin
      v0_nxt          = 1'b1;
      s0_nxt          = res0;
      s0_nxt.run_last = (res_cnt == 2'd1);
      v1_nxt          = (res_cnt == 2'd2);
      s1_nxt          = res1;
      s1_nxt.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  property p_order;
    @(posedge clk) disable iff (!rst_n) v1_r |-> v0_r;
  endproperty
  a_order: assert property (p_order)
    else $error("second slot full with first slot empty");

  property p_pair_last;
    @(posedge clk) disable iff (!rst_n) v1_r |-> (!s0_r.run_last && s1_r.run_last);
  endproperty
  a_pair_last: assert property (p_pair_last)
    else $error("run_last misplaced in a pair");

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n)
      (ld && res_cnt != 2'd0) |-> (!v0_r || (out_ready && !v1_r));
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("result loaded over an undelivered beat");

endmodule

// ----- rtl/core/tim_image_stream_decoder_core.sv -----
// Top level of the TIM image stream decoder: input register, parser, result register.
//
//  channel | dir | tdata                              | tuser                      | tlast
//  in_     | in  | data_byte                          | file_start                 | -
//  out_    | out | pixel_index red green blue alpha   | kind image_kind            | run_last
//          |     | image_done                         |                            |
//
// One byte is taken per cycle while the result register can load; a 4-bit pixel byte
// holds the next byte back, since its two indices leave through the single result port
// one beat each. Each byte passes the input register, then the result register.
// rst_n clears the parser state and both valid stages; the next file starts at tag byte 0.
// With out_tready low the result register holds, and the input register absorbs one beat
// before in_tready drops.
module tim_image_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pixel_index, [12:8] red, [17:13] green,
                                  // [22:18] blue, [30:23] alpha, [31] image_done
  output logic [4:0]  out_tuser,  // [2:0] kind, [4:3] image_kind
  output logic        out_tlast   // run_last
);
  import tisd_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       can_load;
  logic       adv;
  logic [1:0] res_cnt;
  tisd_res_t  res0;
  tisd_res_t  res1;
  tisd_res_t  out_res;

  assign adv       = in_valid_r && can_load;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  tisd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .data_byte  (in_byte_r),
    .file_start (in_start_r),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  tisd_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (adv),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.image_done, out_res.alpha, out_res.blue, out_res.green,
                      out_res.red, out_res.pixel_index};
  assign out_tuser = {out_res.image_kind, out_res.kind};
  assign out_tlast = out_res.run_last;

endmodule
